// ===== design/esc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the epoch-to-calendar converter
// Word layouts of both channels, the reciprocal constants that replace the
// constant divisions, and the small calendar helpers for the years 1970..2106.
// ----------------------------------------------------------------------------
package esc_pkg;

  typedef struct packed {
    logic [31:0] epoch_seconds;
  } esc_in_t;

  typedef struct packed {
    logic [7:0] years_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
  } esc_out_t;

  // Seconds per day is 128 * 675, so the day count is (t >> 7) / 675.
  localparam logic [25:0] Recip675   = 26'd50903317;
  localparam int unsigned Shift675   = 35;
  localparam logic [9:0]  Div675     = 10'd675;
  // Day count divided by 365.
  localparam logic [15:0] Recip365   = 16'd45965;
  localparam int unsigned Shift365   = 24;
  localparam logic [17:0] DaysPerYear = 18'd365;
  // Day count plus four divided by 7 gives the weekday.
  localparam logic [16:0] Recip7     = 17'd74899;
  localparam int unsigned Shift7     = 19;
  localparam logic [16:0] EpochWday  = 17'd4;
  // Values shifted right by two and divided by 15 give a division by 60.
  localparam logic [14:0] Recip60Sod = 15'd17477;
  localparam int unsigned Shift60Sod = 18;
  localparam logic [10:0] Recip60Min = 11'd1093;
  localparam int unsigned Shift60Min = 14;
  localparam logic [5:0]  SecsPerMin = 6'd60;
  // Year offsets from 1970.
  localparam logic [7:0]  BaseYearOff = 8'd70;
  localparam logic [7:0]  YearOff2100 = 8'd130;

  // Number of leap years from 1970 up to the year before 1970 + off.
  function automatic logic [5:0] leaps_before(input logic [7:0] off);
    logic [8:0] np;
    np = 9'(off) + 9'd1;
    return 6'(np[8:2]) - 6'(off > YearOff2100);
  endfunction

  // Leap-year flag of the year 1970 + off.
  function automatic logic year_is_leap(input logic [7:0] off);
    logic [7:0] y;
    y = off + 8'd2;
    return (y[1:0] == 2'b00) && (off != YearOff2100);
  endfunction

  // Zero-based day of year on which month m starts.
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    unique case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + 9'(leap && (m >= 4'd2));
  endfunction

endpackage
`default_nettype wire

// ===== design/esc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_if: valid/ready channels of the epoch-to-calendar converter
// One interface for the timestamp words and one for the calendar words.
// ----------------------------------------------------------------------------
interface esc_in_if;
  logic             valid;
  logic             ready;
  esc_pkg::esc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface esc_out_if;
  logic              valid;
  logic              ready;
  esc_pkg::esc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/esc_month_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_month_walk: day of year to month and day of month
// Compares the zero-based day of year against every month start in parallel
// and picks the last month that has started.
// ----------------------------------------------------------------------------
module esc_month_walk (
  input  wire        [8:0] day_idx_i,
  input  wire              leap_i,
  output logic       [3:0] month_o,
  output logic       [4:0] mday_o
);

  logic [10:0] started;
  logic [8:0]  start;

  always_comb begin
    for (int m = 1; m < 12; m++) begin
      started[m-1] = day_idx_i >= esc_pkg::month_start(4'(m), leap_i);
    end
    month_o = 4'($countones(started));
    start   = esc_pkg::month_start(month_o, leap_i);
    mday_o  = 5'(day_idx_i - start + 9'd1);
  end

endmodule
`default_nettype wire

// ===== design/epoch_seconds_to_calendar.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: Unix seconds to Gregorian calendar fields
// Splits a 32-bit count of seconds since 1970 into year, month, day, weekday,
// day of year, hour, minute and second.
//
//   channel | dir | word                  | handshake
//   in_i    | in  | esc_in_t  (timestamp) | valid / ready
//   out_o   | out | esc_out_t (calendar)  | valid / ready
//
// The converter is a six-stage pipeline that takes one word per cycle while
// the output does not stall. The stage count is set by the chain of
// reciprocal multiplies (day count, then year, weekday and minutes, then
// hours). Each stage advances on its own, so bubbles close up while the
// output waits. Reset clears only the stage valid flags.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input wire clk_i,
  input wire rst_ni,
  esc_in_if.sink    in_i,
  esc_out_if.source out_o
);

  logic [6:1] vld_q;
  logic [6:1] rdy;

  always_comb begin
    rdy[6] = !vld_q[6] || out_o.ready;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_i.ready  = rdy[1];
  assign out_o.valid = vld_q[6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) begin
        vld_q[1] <= in_i.valid;
      end
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 1: input register.
  logic [31:0] t1_q;

  // Stage 2: day count product.
  logic [50:0] p675_d, p675_q;
  logic [31:0] t2_q;
  assign p675_d = 51'(t1_q[31:7]) * 51'(esc_pkg::Recip675);

  // Stage 3: day count and seconds of the day.
  logic [15:0] days3_d, days3_q;
  logic [9:0]  rem675;
  logic [16:0] sod3_d, sod3_q;
  assign days3_d = p675_q[esc_pkg::Shift675 +: 16];
  assign rem675  = t2_q[16:7] - 10'(days3_d[9:0] * esc_pkg::Div675);
  assign sod3_d  = {rem675[9:0], t2_q[6:0]};

  // Stage 4: year, weekday and minute products.
  logic [31:0] p365_d, p365_q;
  logic [33:0] p7_d, p7_q;
  logic [29:0] pmin_d, pmin_q;
  logic [16:0] wk4;
  logic [15:0] days4_q;
  logic [16:0] sod4_q;
  assign wk4    = 17'(days3_q) + esc_pkg::EpochWday;
  assign p365_d = 32'(days3_q) * 32'(esc_pkg::Recip365);
  assign p7_d   = 34'(wk4) * 34'(esc_pkg::Recip7);
  assign pmin_d = 30'(sod3_q[16:2]) * 30'(esc_pkg::Recip60Sod);

  // Stage 5: year correction, weekday, seconds and hour product.
  logic [7:0]         off;
  logic [7:0]         off_prev;
  logic [14:0]        q7;
  logic [10:0]        mt5_d, mt5_q;
  logic [17:0]        year_base;
  logic signed [17:0] d0;
  logic [17:0]        d_fix;
  logic               late;
  logic [7:0]         off_fix;
  logic [7:0]         year5_d, year5_q;
  logic [8:0]         d5_d, d5_q;
  logic               leap5_d, leap5_q;
  logic [2:0]         wday5_d, wday5_q;
  logic [5:0]         sec5_d, sec5_q;
  logic [19:0]        ph5_d, ph5_q;

  always_comb begin
    off       = p365_q[esc_pkg::Shift365 +: 8];
    off_prev  = off - 8'd1;
    q7        = p7_q[esc_pkg::Shift7 +: 15];
    mt5_d     = pmin_q[esc_pkg::Shift60Sod +: 11];
    wday5_d   = 3'(days4_q[2:0] + 3'(esc_pkg::EpochWday)) - 3'(q7[2:0] * 3'd7);
    sec5_d    = sod4_q[5:0] - 6'(mt5_d[5:0] * esc_pkg::SecsPerMin);
    ph5_d     = 20'(mt5_d[10:2]) * 20'(esc_pkg::Recip60Min);
    year_base = 18'(off) * esc_pkg::DaysPerYear + 18'(esc_pkg::leaps_before(off));
    d0        = $signed({2'b00, days4_q}) - $signed(year_base);
    late      = d0[17];
    d_fix     = 18'(d0) + esc_pkg::DaysPerYear + 18'(esc_pkg::year_is_leap(off_prev));
    off_fix   = late ? off_prev : off;
    d5_d      = late ? d_fix[8:0] : d0[8:0];
    year5_d   = off_fix + esc_pkg::BaseYearOff;
    leap5_d   = esc_pkg::year_is_leap(off_fix);
  end

  // Stage 6: hour, minute, month walk and output register.
  logic [4:0]        hour6;
  logic [3:0]        month6;
  logic [4:0]        mday6;
  esc_pkg::esc_out_t out_d, out_q;

  esc_month_walk u_month_walk (
    .day_idx_i (d5_q),
    .leap_i    (leap5_q),
    .month_o   (month6),
    .mday_o    (mday6)
  );

  always_comb begin
    hour6                  = ph5_q[esc_pkg::Shift60Min +: 5];
    out_d.years_since_1900 = year5_q;
    out_d.month_index      = month6;
    out_d.day_of_month     = mday6;
    out_d.weekday          = wday5_q;
    out_d.day_of_year      = d5_q + 9'd1;
    out_d.hour_of_day      = hour6;
    out_d.minute_of_hour   = mt5_q[5:0] - 6'({1'b0, hour6} * esc_pkg::SecsPerMin);
    out_d.second_of_minute = sec5_q;
  end

  assign out_o.data = out_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      t1_q <= in_i.data.epoch_seconds;
    end
    if (rdy[2]) begin
      p675_q <= p675_d;
      t2_q   <= t1_q;
    end
    if (rdy[3]) begin
      days3_q <= days3_d;
      sod3_q  <= sod3_d;
    end
    if (rdy[4]) begin
      p365_q  <= p365_d;
      p7_q    <= p7_d;
      pmin_q  <= pmin_d;
      days4_q <= days3_q;
      sod4_q  <= sod3_q;
    end
    if (rdy[5]) begin
      year5_q <= year5_d;
      d5_q    <= d5_d;
      leap5_q <= leap5_d;
      wday5_q <= wday5_d;
      sec5_q  <= sec5_d;
      mt5_q   <= mt5_d;
      ph5_q   <= ph5_d;
    end
    if (rdy[6]) begin
      out_q <= out_d;
    end
  end

  // An empty output stage means every stage can move, so input is open.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[6] |-> in_i.ready)
    else $error("input blocked while the output stage is empty");

  a_time_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_q.hour_of_day <= 5'd23) && (out_q.minute_of_hour <= 6'd59)
                    && (out_q.second_of_minute <= 6'd59))
    else $error("time of day out of range");

  a_date_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_q.month_index <= 4'd11) && (out_q.day_of_month != 5'd0)
                    && (out_q.weekday <= 3'd6) && (out_q.years_since_1900 >= 8'd70)
                    && (out_q.years_since_1900 <= 8'd206))
    else $error("calendar date out of range");

  a_yday_matches_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      (out_q.day_of_year == esc_pkg::month_start(out_q.month_index, 1'b0)
                            + 9'(out_q.day_of_month))
      || (out_q.day_of_year == esc_pkg::month_start(out_q.month_index, 1'b1)
                               + 9'(out_q.day_of_month)))
    else $error("day of year disagrees with month and day");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for epoch_seconds_to_calendar
// A table of timestamps at the ends of the range and on year, month and leap
// boundaries runs first. Random timestamps follow, spread over the whole
// range and clustered around midnights and the end of February. Both
// channels idle at random. Every calendar word is compared field by field
// with a calendar from the table or computed independently in the bench.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RandomWords = 1050;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned NumRows     = 25;

  typedef struct packed {
    logic [31:0]       seconds;
    logic              typed;
    esc_pkg::esc_out_t want;
  } stim_row_t;

  localparam esc_pkg::esc_out_t NoWant = esc_pkg::esc_out_t'(0);

  localparam stim_row_t DirectedRows [NumRows] = '{
    {32'd0,          1'b1, {8'd70, 4'd0, 5'd1, 3'd4, 9'd1, 5'd0, 6'd0, 6'd0}},
    {32'd86399,      1'b1, {8'd70, 4'd0, 5'd1, 3'd4, 9'd1, 5'd23, 6'd59, 6'd59}},
    {32'd86400,      1'b1, {8'd70, 4'd0, 5'd2, 3'd5, 9'd2, 5'd0, 6'd0, 6'd0}},
    {32'd4294967295, 1'b1, {8'd206, 4'd1, 5'd7, 3'd0, 9'd38, 5'd6, 6'd28, 6'd15}},
    {32'd31535999,   1'b0, NoWant},
    {32'd31536000,   1'b0, NoWant},
    {32'd68169600,   1'b0, NoWant},
    {32'd94694399,   1'b0, NoWant},
    {32'd94694400,   1'b0, NoWant},
    {32'd946684799,  1'b0, NoWant},
    {32'd951782400,  1'b0, NoWant},
    {32'd951868800,  1'b0, NoWant},
    {32'd978307199,  1'b0, NoWant},
    {32'd2147483647, 1'b0, NoWant},
    {32'd2147483648, 1'b0, NoWant},
    {32'd4102444800, 1'b0, NoWant},
    {32'd4107456000, 1'b0, NoWant},
    {32'd4107542400, 1'b0, NoWant},
    {32'd4133980799, 1'b0, NoWant},
    {32'd4133980800, 1'b0, NoWant},
    {32'h5555_5555,  1'b0, NoWant},
    {32'hAAAA_AAAA,  1'b0, NoWant},
    {32'hFFFF_0000,  1'b0, NoWant},
    {32'd4294943999, 1'b0, NoWant},
    {32'd4294944000, 1'b0, NoWant}
  };

  logic clk;
  logic rst_n;
  logic burst_mode;
  int unsigned error_count;
  int unsigned cycle_count;
  esc_pkg::esc_out_t pending_dates [$];

  esc_in_if  in_ch ();
  esc_out_if out_ch ();

  epoch_seconds_to_calendar dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  function automatic bit is_leap(input int yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int leaps_upto(input int yr);
    return yr / 4 - yr / 100 + yr / 400;
  endfunction

  function automatic esc_pkg::esc_out_t calendar_of(input logic [31:0] t);
    int days;
    int sod;
    int yr;
    int d;
    int m;
    int len;
    esc_pkg::esc_out_t r;
    days = int'(t / 32'd86400);
    sod  = int'(t % 32'd86400);
    yr   = 1970 + days / 365;
    d    = days - ((yr - 1970) * 365 + leaps_upto(yr - 1) - leaps_upto(1969));
    if (d < 0) begin
      yr = yr - 1;
      d  = d + 365 + int'(is_leap(yr));
    end
    r.day_of_year = 9'(d + 1);
    r.weekday     = 3'((days + 4) % 7);
    m = 0;
    while (m < 11) begin
      case (m)
        1:       len = 28 + int'(is_leap(yr));
        3, 5, 8, 10: len = 30;
        default: len = 31;
      endcase
      if (d < len) break;
      d = d - len;
      m = m + 1;
    end
    r.years_since_1900 = 8'(yr - 1900);
    r.month_index      = 4'(m);
    r.day_of_month     = 5'(d + 1);
    r.hour_of_day      = 5'(sod / 3600);
    r.minute_of_hour   = 6'((sod % 3600) / 60);
    r.second_of_minute = 6'(sod % 60);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_seconds();
    logic [31:0] day;
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: begin
        day = $urandom_range(0, 49710);
        case ($urandom_range(0, 3))
          0:       return day * 32'd86400;
          1:       return day * 32'd86400 - 32'd1;
          2:       return day * 32'd86400 + $urandom_range(0, 59);
          default: return day * 32'd86400 + $urandom_range(86340, 86399);
        endcase
      end
      default: begin
        day = $urandom_range(0, 136);
        day = day * 32'd365 + day / 32'd4 + $urandom_range(55, 62);
        return day * 32'd86400 + $urandom_range(0, 86399);
      end
    endcase
  endfunction

  task automatic send_word(input logic [31:0] seconds, input bit typed,
                           input esc_pkg::esc_out_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= seconds;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_dates.push_back(typed ? want : calendar_of(seconds));
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[epoch_seconds_to_calendar] ERROR");
    $finish;
  end

  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    esc_pkg::esc_out_t want;
    esc_pkg::esc_out_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_dates.size() == 0) begin
        error_count++;
        $display("%0t: unexpected calendar word %h, expected none", $time, got);
      end else begin
        want = pending_dates.pop_front();
        check_field("years_since_1900", want.years_since_1900, got.years_since_1900);
        check_field("month_index", want.month_index, got.month_index);
        check_field("day_of_month", want.day_of_month, got.day_of_month);
        check_field("weekday", want.weekday, got.weekday);
        check_field("day_of_year", want.day_of_year, got.day_of_year);
        check_field("hour_of_day", want.hour_of_day, got.hour_of_day);
        check_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
        check_field("second_of_minute", want.second_of_minute, got.second_of_minute);
      end
    end
  end

  initial begin
    error_count = 0;
    burst_mode  = 1'b0;
    rst_n       = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NumRows; i++) begin
      send_word(DirectedRows[i].seconds, DirectedRows[i].typed, DirectedRows[i].want);
    end
    for (int unsigned i = 0; i < RandomWords; i++) begin
      if (i % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_word(random_seconds(), 1'b0, NoWant);
    end
    in_ch.valid <= 1'b0;
    burst_mode = 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("[epoch_seconds_to_calendar] OK");
    end else begin
      $display("[epoch_seconds_to_calendar] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/esc_pkg.sv
design/esc_if.sv
design/esc_month_walk.sv
design/epoch_seconds_to_calendar.sv
verif/testbench.sv
